/* sv/ams_pkg.sv */
// shared types and constants of the accumulator machine step unit
package ams_pkg;

   // memory size and decimal encoding
   localparam int MEM_WORDS_DEF = 100;
   localparam int DEC_BASE = 100;
   localparam int PC_W = 7;
   localparam int DATA_W = 32;
   localparam int OPC_W = 6;
   localparam int DEC_W = 13;

   // executable words lie in [1000, 4400)
   localparam logic [DEC_W-1:0] WORD_LO = 13'd1000;
   localparam logic [DEC_W-1:0] WORD_HI = 13'd4400;

   // word / 100 as (word * 5243) >> 19, exact below 8192
   localparam logic [DEC_W-1:0] RECIP_MUL = 13'd5243;
   localparam int RECIP_SH = 19;

   // item operations
   localparam logic [1:0] OPER_LOAD = 2'd0;
   localparam logic [1:0] OPER_EXEC = 2'd1;
   localparam logic [1:0] OPER_RESTART = 2'd2;

   // instruction opcodes
   localparam logic [OPC_W-1:0] OPC_READ = 6'd10;
   localparam logic [OPC_W-1:0] OPC_WRITE = 6'd11;
   localparam logic [OPC_W-1:0] OPC_LOAD = 6'd20;
   localparam logic [OPC_W-1:0] OPC_STORE = 6'd21;
   localparam logic [OPC_W-1:0] OPC_ADD = 6'd30;
   localparam logic [OPC_W-1:0] OPC_SUB = 6'd31;
   localparam logic [OPC_W-1:0] OPC_DIV = 6'd32;
   localparam logic [OPC_W-1:0] OPC_MUL = 6'd33;
   localparam logic [OPC_W-1:0] OPC_JUMP = 6'd40;
   localparam logic [OPC_W-1:0] OPC_JUMPNEG = 6'd41;
   localparam logic [OPC_W-1:0] OPC_JUMPZERO = 6'd42;
   localparam logic [OPC_W-1:0] OPC_HALT = 6'd43;

   // result status codes
   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_HALTED = 2'd1;
   localparam logic [1:0] STAT_UNKNOWN = 2'd2;
   localparam logic [1:0] STAT_DIVZERO = 2'd3;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

endpackage

/* sv/ams_ram.sv */
// generic single write port, single read port ram with registered read
module ams_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/ams_alu.sv */
// shared arithmetic unit: add, sub and mul with a registered result, signed divide one bit a cycle
module ams_alu
   import ams_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_req_type       alu_req,
   input  logic [DATA_W-1:0] opa,
   input  logic [DATA_W-1:0] opb,
   output logic              done,
   output logic [DATA_W-1:0] result
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] result_ff, result_in;

   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   rem_diff;
   logic [DATA_W-1:0] abs_a;
   logic [DATA_W-1:0] abs_b;

   assign abs_a = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
   assign abs_b = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
   assign rem_sh = {rem_ff, quo_ff[DATA_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      result_in = result_ff;
      if (busy_ff) begin
         // restoring step on magnitudes
         if (!rem_diff[DATA_W]) begin
            rem_in = rem_diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            result_in = neg_ff ? (~quo_in + 1'b1) : quo_in;
         end
      end else if (alu_req.start) begin
         case (alu_req.op)
            ALU_ADD: begin
               result_in = opa + opb;
               done_in = 1'b1;
            end
            ALU_SUB: begin
               result_in = opa - opb;
               done_in = 1'b1;
            end
            ALU_MUL: begin
               result_in = opa * opb;
               done_in = 1'b1;
            end
            default: begin
               busy_in = 1'b1;
               count_in = CNT_W'(DATA_W - 1);
               rem_in = '0;
               quo_in = abs_a;
               den_in = abs_b;
               neg_in = opa[DATA_W-1] ^ opb[DATA_W-1];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      result_ff <= result_in;
   end

   assign done = done_ff;
   assign result = result_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> !busy_ff)
      else $error("alu started while a divide is running");

endmodule

/* sv/accumulator_machine_step_unit.sv */
// top level: sequencer, memory and state of the accumulator machine
// Executes one decimal-coded accumulator machine word per item (opcode * 100 + operand),
// or loads a memory word, or restarts at address zero; every item returns one result
// word with pc, accumulator, write output and status. A load, restart, unused operation
// or execute while halted goes from the idle state straight to the finish state, and a
// word that fails to decode at fetch goes there from the fetch check. An executed
// instruction uses the single read port of the program memory twice (instruction fetch,
// then operand fetch) with the fetch check and the opcode decode between them, then an
// execute step and a step to hand the result over. Add, subtract and multiply wait in the
// shared arithmetic unit for its registered result, and divide takes one quotient bit a
// cycle. The memory reads as zero after reset through one valid bit per word, so no
// clearing pass is needed. The input side waits for the sequencer only; a finished
// result sits in its own output register and the next word is taken while it waits,
// and a result still held there when the next one finishes holds the sequencer until
// it is taken.
module accumulator_machine_step_unit
   import ams_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [PC_W-1:0]   req_load_address,
   input  logic [DATA_W-1:0] req_load_word,
   input  logic [DATA_W-1:0] req_read_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PC_W-1:0]   rsp_next_pc,
   output logic [DATA_W-1:0] rsp_acc_value,
   output logic              rsp_write_valid,
   output logic [DATA_W-1:0] rsp_write_value,
   output logic [1:0]        rsp_status
);

   localparam int ADDR_W = $clog2(MEM_WORDS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_FETCH  = 7'b0000010,
      ST_DECODE = 7'b0000100,
      ST_ADDR   = 7'b0001000,
      ST_EXEC   = 7'b0010000,
      ST_ALU    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic              halted_ff, halted_in;
   logic [DATA_W-1:0] rdval_ff, rdval_in;
   logic [DEC_W-1:0]  word_ff, word_in;
   logic [OPC_W-1:0]  opc_ff, opc_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              res_wvalid_ff, res_wvalid_in;
   logic [DATA_W-1:0] res_wvalue_ff, res_wvalue_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PC_W-1:0]   rsp_pc_ff, rsp_pc_in;
   logic [DATA_W-1:0] rsp_acc_ff, rsp_acc_in;
   logic              rsp_wvalid_ff, rsp_wvalid_in;
   logic [DATA_W-1:0] rsp_wvalue_ff, rsp_wvalue_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic              valid_ff [MEM_WORDS];
   logic              rvalid_ff;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [DATA_W-1:0] ram_rdata;
   logic [DATA_W-1:0] mem_word;

   alu_req_type       alu_req;
   logic              alu_done;
   logic [DATA_W-1:0] alu_result;

   logic [ADDR_W-1:0] fold_tbl [DEC_BASE];
   logic [25:0]       recip_prod;
   logic [DEC_W-1:0]  rem_full;
   logic [ADDR_W-1:0] pc_next;
   logic              word_ok;
   logic              rsp_free;

   // operand field folded onto the memory size
   for (genvar i = 0; i < DEC_BASE; i++) begin : g_fold
      assign fold_tbl[i] = ADDR_W'(i % MEM_WORDS);
   end

   ams_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_WORDS)
   ) u_mem (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ams_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .opa     (acc_ff),
      .opb     (mem_word),
      .done    (alu_done),
      .result  (alu_result)
   );

   // words never written read as zero
   assign mem_word = rvalid_ff ? ram_rdata : '0;
   assign word_ok = (mem_word[DATA_W-1:DEC_W] == '0) && (mem_word[DEC_W-1:0] >= WORD_LO)
                    && (mem_word[DEC_W-1:0] < WORD_HI);
   assign recip_prod = 26'(word_ff) * 26'(RECIP_MUL);
   assign rem_full = word_ff - 13'(opc_ff) * 13'(DEC_BASE);
   assign pc_next = (pc_ff == LAST_ADDR) ? '0 : pc_ff + 1'b1;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      pc_in = pc_ff;
      halted_in = halted_ff;
      rdval_in = rdval_ff;
      word_in = word_ff;
      opc_in = opc_ff;
      addr_in = addr_ff;
      res_wvalid_in = res_wvalid_ff;
      res_wvalue_in = res_wvalue_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pc_in = rsp_pc_ff;
      rsp_acc_in = rsp_acc_ff;
      rsp_wvalid_in = rsp_wvalid_ff;
      rsp_wvalue_in = rsp_wvalue_ff;
      rsp_status_in = rsp_status_ff;
      ram_we = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = acc_ff;
      ram_re = 1'b0;
      ram_raddr = pc_ff;
      alu_req.start = 1'b0;
      alu_req.op = ALU_ADD;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_wvalid_in = 1'b0;
               res_wvalue_in = '0;
               res_status_in = STAT_OK;
               rdval_in = req_read_value;
               state_in = ST_FINISH;
               case (req_operation)
                  OPER_LOAD: begin
                     if (req_load_address < PC_W'(MEM_WORDS)) begin
                        ram_we = 1'b1;
                        ram_waddr = req_load_address[ADDR_W-1:0];
                        ram_wdata = req_load_word;
                     end
                  end
                  OPER_EXEC: begin
                     if (halted_ff) begin
                        res_status_in = STAT_HALTED;
                     end else begin
                        ram_re = 1'b1;
                        state_in = ST_FETCH;
                     end
                  end
                  OPER_RESTART: begin
                     pc_in = '0;
                     acc_in = '0;
                     halted_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            word_in = mem_word[DEC_W-1:0];
            if (word_ok) begin
               state_in = ST_DECODE;
            end else begin
               // negative or oversized word, or opcode field below 10 or above 43
               res_status_in = STAT_UNKNOWN;
               pc_in = pc_next;
               state_in = ST_FINISH;
            end
         end
         ST_DECODE: begin
            opc_in = recip_prod[RECIP_SH +: OPC_W];
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            addr_in = fold_tbl[rem_full[PC_W-1:0]];
            ram_re = 1'b1;
            ram_raddr = addr_in;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            pc_in = pc_next;
            state_in = ST_FINISH;
            unique case (opc_ff)
               OPC_READ: begin
                  ram_we = 1'b1;
                  ram_wdata = rdval_ff;
               end
               OPC_WRITE: begin
                  res_wvalid_in = 1'b1;
                  res_wvalue_in = mem_word;
               end
               OPC_LOAD: begin
                  acc_in = mem_word;
               end
               OPC_STORE: begin
                  ram_we = 1'b1;
               end
               OPC_ADD: begin
                  alu_req.start = 1'b1;
                  alu_req.op = ALU_ADD;
                  pc_in = pc_ff;
                  state_in = ST_ALU;
               end
               OPC_SUB: begin
                  alu_req.start = 1'b1;
                  alu_req.op = ALU_SUB;
                  pc_in = pc_ff;
                  state_in = ST_ALU;
               end
               OPC_MUL: begin
                  alu_req.start = 1'b1;
                  alu_req.op = ALU_MUL;
                  pc_in = pc_ff;
                  state_in = ST_ALU;
               end
               OPC_DIV: begin
                  if (mem_word == '0) begin
                     res_status_in = STAT_DIVZERO;
                  end else begin
                     alu_req.start = 1'b1;
                     alu_req.op = ALU_DIV;
                     pc_in = pc_ff;
                     state_in = ST_ALU;
                  end
               end
               OPC_JUMP: begin
                  pc_in = addr_ff;
               end
               OPC_JUMPNEG: begin
                  if (acc_ff[DATA_W-1]) begin
                     pc_in = addr_ff;
                  end
               end
               OPC_JUMPZERO: begin
                  if (acc_ff == '0) begin
                     pc_in = addr_ff;
                  end
               end
               OPC_HALT: begin
                  // pc stays on the halt word
                  pc_in = pc_ff;
                  halted_in = 1'b1;
                  res_status_in = STAT_HALTED;
               end
               default: begin
                  res_status_in = STAT_UNKNOWN;
               end
            endcase
         end
         ST_ALU: begin
            if (alu_done) begin
               acc_in = alu_result;
               pc_in = pc_next;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pc_in = PC_W'(pc_ff);
               rsp_acc_in = acc_ff;
               rsp_wvalid_in = res_wvalid_ff;
               rsp_wvalue_in = res_wvalue_ff;
               rsp_status_in = res_status_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff <= '0;
         pc_ff <= '0;
         halted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < MEM_WORDS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         pc_ff <= pc_in;
         halted_ff <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         if (ram_re) begin
            rvalid_ff <= valid_ff[ram_raddr];
         end
      end
      rdval_ff <= rdval_in;
      word_ff <= word_in;
      opc_ff <= opc_in;
      addr_ff <= addr_in;
      res_wvalid_ff <= res_wvalid_in;
      res_wvalue_ff <= res_wvalue_in;
      res_status_ff <= res_status_in;
      rsp_pc_ff <= rsp_pc_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_wvalid_ff <= rsp_wvalid_in;
      rsp_wvalue_ff <= rsp_wvalue_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_next_pc = rsp_pc_ff;
   assign rsp_acc_value = rsp_acc_ff;
   assign rsp_write_valid = rsp_wvalid_ff;
   assign rsp_write_value = rsp_wvalue_ff;
   assign rsp_status = rsp_status_ff;

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_re)
      else $error("memory written and read in the same cycle");

   a_alu_done_state: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == ST_ALU)
      else $error("alu finished outside the alu wait state");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= LAST_ADDR)
      else $error("program counter beyond the last word");

   a_halt_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(halted_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("halt flag set outside instruction execution");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && !rsp_valid_ff |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished word not moved to the output register");

endmodule
